/* rtl/core/brfw_pkg.sv */
// Shared types and constants for the byte ring FIFO with watermark.
package brfw_pkg;

  localparam int DEPTH    = 256;
  localparam int ADDR_W   = 8;
  localparam int SIZE_W   = 9;
  localparam int SIZE_CAP = (DEPTH < 256) ? DEPTH : 256;
  localparam int MIN_FREE = 2;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  typedef logic [ADDR_W-1:0] ptr_t;
  typedef logic [SIZE_W-1:0] cnt_t;
  typedef logic [7:0]        data_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    data_t wdata;
    logic  re;
    ptr_t  raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [7:0]  used;
    cnt_t        free;
    cnt_t        low;
    logic [15:0] ovf;
    logic        empty;
    logic        full;
  } stat_t;

endpackage

/* rtl/core/brfw_store.sv */
// Byte store: one write port and one registered read port.
module brfw_store (
  input  logic                clk,
  input  brfw_pkg::mem_cmd_t  cmd,
  output brfw_pkg::data_t     rdata
);

  brfw_pkg::data_t mem [brfw_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata <= mem[cmd.raddr];
    end
  end

endmodule

/* rtl/core/brfw_ctrl.sv */
// Pointer, watermark and overflow control for the byte ring FIFO.
module brfw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                size_we,
  input  brfw_pkg::cnt_t      size_wdata,
  input  logic                acc,
  input  logic [1:0]          req_type,
  input  brfw_pkg::data_t     data_in,
  input  logic [15:0]         remove_count,
  output brfw_pkg::mem_cmd_t  mem_cmd,
  output brfw_pkg::stat_t     stat,
  output logic                done,
  output logic                ok_q,
  output logic                get_q
);

  brfw_pkg::cnt_t size;
  brfw_pkg::ptr_t read_ptr;
  brfw_pkg::ptr_t write_ptr;
  brfw_pkg::cnt_t low_free_mark;
  logic [15:0]    overflows;

  brfw_pkg::cnt_t used_cur;
  brfw_pkg::cnt_t free_cur;
  logic           empty_cur;
  logic           add_ok;
  brfw_pkg::cnt_t wp_inc;
  brfw_pkg::cnt_t rp_inc;
  brfw_pkg::cnt_t rm_cnt;
  brfw_pkg::cnt_t rp_sum;
  brfw_pkg::ptr_t wp_adv;
  brfw_pkg::ptr_t rp_adv;
  brfw_pkg::ptr_t rp_rm;
  brfw_pkg::cnt_t cfg_size;
  logic           ok_now;

  always_comb begin
    if (write_ptr >= read_ptr) begin
      used_cur = {1'b0, write_ptr} - {1'b0, read_ptr};
    end else begin
      used_cur = size + {1'b0, write_ptr} - {1'b0, read_ptr};
    end
    free_cur  = size - used_cur;
    empty_cur = (read_ptr == write_ptr);
    add_ok    = (free_cur >= brfw_pkg::cnt_t'(brfw_pkg::MIN_FREE));

    wp_inc = {1'b0, write_ptr} + 9'd1;
    wp_adv = (wp_inc >= size) ? '0 : wp_inc[7:0];
    rp_inc = {1'b0, read_ptr} + 9'd1;
    rp_adv = (rp_inc >= size) ? '0 : rp_inc[7:0];

    rm_cnt = (remove_count > {7'd0, used_cur}) ? used_cur : remove_count[8:0];
    rp_sum = {1'b0, read_ptr} + rm_cnt;
    if (rp_sum >= size) begin
      rp_rm = 8'(rp_sum - size);
    end else begin
      rp_rm = rp_sum[7:0];
    end

    if (size_wdata < brfw_pkg::cnt_t'(brfw_pkg::MIN_FREE)) begin
      cfg_size = brfw_pkg::cnt_t'(brfw_pkg::MIN_FREE);
    end else if (size_wdata > brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP)) begin
      cfg_size = brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP);
    end else begin
      cfg_size = size_wdata;
    end

    unique case (req_type)
      brfw_pkg::REQ_ADD: ok_now = add_ok;
      brfw_pkg::REQ_GET: ok_now = !empty_cur;
      default:           ok_now = 1'b1;
    endcase
  end

  always_comb begin
    mem_cmd.we    = acc && (req_type == brfw_pkg::REQ_ADD) && add_ok;
    mem_cmd.waddr = write_ptr;
    mem_cmd.wdata = data_in;
    mem_cmd.re    = acc && (req_type == brfw_pkg::REQ_GET) && !empty_cur;
    mem_cmd.raddr = read_ptr;

    stat.used  = used_cur[7:0];
    stat.free  = free_cur;
    stat.low   = low_free_mark;
    stat.ovf   = overflows;
    stat.empty = empty_cur;
    stat.full  = !add_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size          <= brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP);
      read_ptr      <= '0;
      write_ptr     <= '0;
      overflows     <= '0;
      low_free_mark <= brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP);
      done          <= 1'b0;
      ok_q          <= 1'b0;
      get_q         <= 1'b0;
    end else begin
      done  <= acc;
      ok_q  <= ok_now;
      get_q <= mem_cmd.re;
      if (size_we) begin
        size          <= cfg_size;
        read_ptr      <= '0;
        write_ptr     <= '0;
        overflows     <= '0;
        low_free_mark <= cfg_size;
      end else if (acc) begin
        unique case (req_type)
          brfw_pkg::REQ_ADD: begin
            if (free_cur < low_free_mark) begin
              low_free_mark <= free_cur;
            end
            if (add_ok) begin
              write_ptr <= wp_adv;
            end else begin
              overflows <= overflows + 16'd1;
            end
          end
          brfw_pkg::REQ_GET: begin
            if (!empty_cur) begin
              read_ptr <= rp_adv;
            end
          end
          brfw_pkg::REQ_REMOVE: begin
            read_ptr <= rp_rm;
          end
          default: begin
            if (free_cur < low_free_mark) begin
              low_free_mark <= free_cur;
            end
          end
        endcase
      end
    end
  end

  // Both pointers stay inside the ring in use.
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, read_ptr} < size) && ({1'b0, write_ptr} < size))
    else $error("pointer outside ring");

  // The FIFO never holds more than size minus one bytes.
  assert property (@(posedge clk) disable iff (rst) free_cur >= 9'd1)
    else $error("ring overfilled");

  // The watermark never rises above the ring size.
  assert property (@(posedge clk) disable iff (rst) low_free_mark <= size)
    else $error("watermark above size");

  // A refused add bumps the overflow counter by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (acc && !size_we && (req_type == brfw_pkg::REQ_ADD) && !add_ok)
      |=> (rst || overflows == $past(overflows) + 16'd1))
    else $error("overflow count not bumped");

  // A successful get never reads the entry the write pointer points at.
  assert property (@(posedge clk) disable iff (rst)
    mem_cmd.re |-> (mem_cmd.raddr != write_ptr))
    else $error("read of unwritten slot");

endmodule

/* rtl/core/byte_ring_fifo_watermark_core.sv */
// Top level of the byte ring FIFO with free-space watermark and overflow count.
//
//  channel   | ports                                   | transfer when
//  ----------+-----------------------------------------+----------------------------
//  request   | start, busy, req_type, data_in,          | start high, busy low
//            | remove_count                             |
//  result    | done, ok, data_out, used_count,          | done high (one cycle only)
//            | free_count, low_mark, overflow_count,    |
//            | is_empty, is_full                        |
//  size reg  | size_we, size_wdata                      | size_we high
//
// A request transfers at an edge and its result appears in the next cycle with done
// high. Requests may be issued every cycle; busy is always low, so the block
// takes one request per clock. The result is registered to match the registered
// read port of the byte store: a get issues its read at the transfer edge and
// the popped byte comes back on the next cycle alongside the counts.
// Reset (synchronous, active high) sets the ring size to 256, clears both
// pointers and the overflow counter, and sets the watermark to the size. The
// store contents are not cleared; a slot is only read after it was written.
// The receiver cannot stall results, so no result queue is needed.
module byte_ring_fifo_watermark_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_in,
  input  logic [15:0] remove_count,
  input  logic        size_we,
  input  logic [8:0]  size_wdata,
  output logic        done,
  output logic        ok,
  output logic [7:0]  data_out,
  output logic [7:0]  used_count,
  output logic [8:0]  free_count,
  output logic [8:0]  low_mark,
  output logic [15:0] overflow_count,
  output logic        is_empty,
  output logic        is_full
);

  brfw_pkg::mem_cmd_t mem_cmd;
  brfw_pkg::stat_t    stat;
  brfw_pkg::data_t    rdata;
  logic               acc;
  logic               get_q;

  // Every request completes in a single pass, so the block never holds off.
  assign busy = 1'b0;
  assign acc  = start && !busy;

  brfw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .size_we      (size_we),
    .size_wdata   (size_wdata),
    .acc          (acc),
    .req_type     (req_type),
    .data_in      (data_in),
    .remove_count (remove_count),
    .mem_cmd      (mem_cmd),
    .stat         (stat),
    .done         (done),
    .ok_q         (ok),
    .get_q        (get_q)
  );

  brfw_store u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .rdata (rdata)
  );

  // The counts are taken from the pointer registers, which already hold the
  // state left by the request being reported. Only a successful get shows the
  // popped byte; everything else reports zero.
  always_comb begin
    data_out       = get_q ? rdata : 8'd0;
    used_count     = stat.used;
    free_count     = stat.free;
    low_mark       = stat.low;
    overflow_count = stat.ovf;
    is_empty       = stat.empty;
    is_full        = stat.full;
  end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the byte ring FIFO with watermark and overflow count.
module testbench;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  // Quiet cycles after the last result before the size register is touched.
  // The block answers in the cycle after a transfer, so this margin is plenty.
  localparam int SETTLE_CYCLES = 4;
  // Longest legitimate stretch without any transfer is one sender gap plus the
  // settle time before a size write. The limit sits far above that.
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_GAP      = 11;
  localparam int RANDOM_ITEMS = 950;
  localparam int MIN_SIZE     = 2;

  // Entries of the stimulus queue. Size writes and drain points both make the
  // driver wait until every outstanding reply has come back.
  typedef enum logic [1:0] {OP_REQUEST, OP_RESIZE, OP_DRAIN} op_kind_t;

  typedef struct packed {
    op_kind_t        kind;
    logic [1:0]      req;
    brfw_pkg::data_t data;
    logic [15:0]     count;
    brfw_pkg::cnt_t  size;
    logic [3:0]      gap;
  } fifo_op_t;

  typedef struct packed {
    logic            ok;
    brfw_pkg::data_t data;
    logic [7:0]      used;
    brfw_pkg::cnt_t  free;
    brfw_pkg::cnt_t  low;
    logic [15:0]     ovf;
    logic            empty;
    logic            full;
  } fifo_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = brfw_pkg::REQ_STATUS;
  logic [7:0]  data_in = '0;
  logic [15:0] remove_count = '0;
  logic        size_we = 1'b0;
  logic [8:0]  size_wdata = '0;
  logic        done;
  logic        ok;
  logic [7:0]  data_out;
  logic [7:0]  used_count;
  logic [8:0]  free_count;
  logic [8:0]  low_mark;
  logic [15:0] overflow_count;
  logic        is_empty;
  logic        is_full;

  always #HALF_PERIOD clk = ~clk;

  byte_ring_fifo_watermark_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .data_in(data_in),
    .remove_count(remove_count),
    .size_we(size_we),
    .size_wdata(size_wdata),
    .done(done),
    .ok(ok),
    .data_out(data_out),
    .used_count(used_count),
    .free_count(free_count),
    .low_mark(low_mark),
    .overflow_count(overflow_count),
    .is_empty(is_empty),
    .is_full(is_full)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the ring, its pointers, the watermark,
  // the refused-add counter and the size in use.
  // ---------------------------------------------------------------------------
  brfw_pkg::cnt_t  ring_size;
  int              rd_ptr;
  int              wr_ptr;
  brfw_pkg::cnt_t  free_low;
  logic [15:0]     refused_adds;
  brfw_pkg::data_t ring_bytes [brfw_pkg::DEPTH];

  function automatic int bytes_held();
    if (wr_ptr < rd_ptr) return int'(ring_size) + wr_ptr - rd_ptr;
    return wr_ptr - rd_ptr;
  endfunction

  // A size write clamps the value into the legal range and restarts the ring.
  // The stored bytes are kept, but the pointers never reach a stale slot.
  function automatic void resize_ring(brfw_pkg::cnt_t value);
    int s;
    s = int'(value);
    if (s < MIN_SIZE) s = MIN_SIZE;
    if (s > brfw_pkg::SIZE_CAP) s = brfw_pkg::SIZE_CAP;
    ring_size    = brfw_pkg::cnt_t'(s);
    rd_ptr       = 0;
    wr_ptr       = 0;
    refused_adds = '0;
    free_low     = brfw_pkg::cnt_t'(s);
  endfunction

  function automatic fifo_reply_t predict_fifo_reply(fifo_op_t op);
    fifo_reply_t r;
    int room;
    int take;
    r    = '0;
    r.ok = 1'b1;
    room = int'(ring_size) - bytes_held();
    // Only adds and status queries move the watermark, and they use the room
    // measured before the request acts.
    if ((op.req == brfw_pkg::REQ_ADD || op.req == brfw_pkg::REQ_STATUS) &&
        room < int'(free_low))
      free_low = brfw_pkg::cnt_t'(room);
    case (op.req)
      brfw_pkg::REQ_ADD: begin
        if (room < brfw_pkg::MIN_FREE) begin
          refused_adds = refused_adds + 16'd1;
          r.ok = 1'b0;
        end else begin
          ring_bytes[wr_ptr] = op.data;
          wr_ptr++;
          if (wr_ptr >= int'(ring_size)) wr_ptr = 0;
        end
      end
      brfw_pkg::REQ_GET: begin
        if (rd_ptr == wr_ptr) begin
          r.ok = 1'b0;
        end else begin
          r.data = ring_bytes[rd_ptr];
          rd_ptr++;
          if (rd_ptr >= int'(ring_size)) rd_ptr = 0;
        end
      end
      brfw_pkg::REQ_REMOVE: begin
        take = int'(op.count);
        if (take > bytes_held()) take = bytes_held();
        rd_ptr += take;
        if (rd_ptr >= int'(ring_size)) rd_ptr -= int'(ring_size);
      end
      default: begin
      end
    endcase
    take    = bytes_held();
    r.used  = take[7:0];
    r.free  = brfw_pkg::cnt_t'(int'(ring_size) - take);
    r.low   = free_low;
    r.ovf   = refused_adds;
    r.empty = (rd_ptr == wr_ptr);
    r.full  = (int'(ring_size) - take) < brfw_pkg::MIN_FREE;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue and the helpers that fill it at time zero.
  // ---------------------------------------------------------------------------
  fifo_op_t    pending_ops[$];
  fifo_reply_t expected_replies[$];
  logic        no_idle = 1'b0;

  function automatic void push_request(logic [1:0] req, brfw_pkg::data_t data,
                                       logic [15:0] count);
    fifo_op_t op;
    op       = '0;
    op.kind  = OP_REQUEST;
    op.req   = req;
    op.data  = data;
    op.count = count;
    op.gap   = no_idle ? 4'd0 : 4'($urandom_range(0, MAX_GAP));
    pending_ops.push_back(op);
  endfunction

  function automatic void push_control(op_kind_t kind, brfw_pkg::cnt_t size);
    fifo_op_t op;
    op      = '0;
    op.kind = kind;
    op.size = size;
    pending_ops.push_back(op);
  endfunction

  // The weights set the mix of adds, gets and removes; the rest are status
  // queries. Unused fields carry random noise.
  function automatic void push_random_request(int add_w, int get_w, int rem_w);
    int              pick;
    logic [15:0]     cnt;
    brfw_pkg::data_t byte_val;
    pick     = $urandom_range(0, 99);
    byte_val = brfw_pkg::data_t'($urandom);
    case ($urandom_range(0, 3))
      0:       cnt = 16'($urandom);
      1:       cnt = 16'($urandom_range(0, 300));
      default: cnt = 16'($urandom_range(0, 4));
    endcase
    if (pick < add_w)
      push_request(brfw_pkg::REQ_ADD, byte_val, cnt);
    else if (pick < add_w + get_w)
      push_request(brfw_pkg::REQ_GET, byte_val, cnt);
    else if (pick < add_w + get_w + rem_w)
      push_request(brfw_pkg::REQ_REMOVE, byte_val, cnt);
    else
      push_request(brfw_pkg::REQ_STATUS, byte_val, cnt);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. At each rising edge it first books the transfer that the edge
  // completes, then decides what the inputs carry for the next cycle. All
  // inputs are driven with nonblocking assignments only.
  // ---------------------------------------------------------------------------
  int       issued_count = 0;
  int       replies_seen = 0;
  int       quiet_cycles = 0;
  int       gap_left = 0;
  logic     gap_served = 1'b0;
  logic     drained = 1'b0;
  fifo_op_t head_op;
  fifo_op_t taken_op;

  always @(posedge clk) begin
    if (rst) begin
      start        <= 1'b0;
      size_we      <= 1'b0;
      quiet_cycles <= 0;
      drained      <= 1'b0;
    end else begin
      size_we <= 1'b0;
      if (start && !busy) begin
        // The ports still show what was driven for the transfer at this edge.
        taken_op       = '0;
        taken_op.kind  = OP_REQUEST;
        taken_op.req   = req_type;
        taken_op.data  = data_in;
        taken_op.count = remove_count;
        expected_replies.push_back(predict_fifo_reply(taken_op));
        issued_count++;
      end
      quiet_cycles <= (issued_count == replies_seen) ? quiet_cycles + 1 : 0;
      // Sampled before this edge pops anything, so the last request is never
      // mistaken for an empty queue.
      drained <= (pending_ops.size() == 0) && (issued_count == replies_seen) &&
                 (quiet_cycles >= SETTLE_CYCLES);

      if (start && busy) begin
        // Hold the request until the block takes it.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_ops.size() == 0) begin
        start <= 1'b0;
      end else if (pending_ops[0].kind != OP_REQUEST) begin
        start <= 1'b0;
        // Size writes and drain points wait until the block is idle.
        if (issued_count == replies_seen && quiet_cycles >= SETTLE_CYCLES) begin
          head_op = pending_ops.pop_front();
          if (head_op.kind == OP_RESIZE) begin
            size_we    <= 1'b1;
            size_wdata <= head_op.size;
            resize_ring(head_op.size);
          end
        end
      end else if (!gap_served && pending_ops[0].gap != 0) begin
        start      <= 1'b0;
        gap_left   = int'(pending_ops[0].gap) - 1;
        gap_served = 1'b1;
      end else begin
        head_op      = pending_ops.pop_front();
        start        <= 1'b1;
        req_type     <= head_op.req;
        data_in      <= head_op.data;
        remove_count <= head_op.count;
        gap_served   = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. A result is on the ports for the one cycle in which done is high
  // and is compared with the oldest expectation at the edge that ends it.
  // ---------------------------------------------------------------------------
  int          failures = 0;
  fifo_reply_t seen_reply;
  fifo_reply_t want_reply;

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      replies_seen <= replies_seen + 1;
      seen_reply = {ok, data_out, used_count, free_count, low_mark, overflow_count,
                    is_empty, is_full};
      if (expected_replies.size() == 0) begin
        $error("result transfer with no request outstanding");
        failures++;
      end else begin
        want_reply = expected_replies.pop_front();
        check_field("ok", 16'(want_reply.ok), 16'(seen_reply.ok));
        check_field("data_out", 16'(want_reply.data), 16'(seen_reply.data));
        check_field("used_count", 16'(want_reply.used), 16'(seen_reply.used));
        check_field("free_count", 16'(want_reply.free), 16'(seen_reply.free));
        check_field("low_mark", 16'(want_reply.low), 16'(seen_reply.low));
        check_field("overflow_count", want_reply.ovf, seen_reply.ovf);
        check_field("is_empty", 16'(want_reply.empty), 16'(seen_reply.empty));
        check_field("is_full", 16'(want_reply.full), 16'(seen_reply.full));
      end
    end
  end

  // Watchdog: ends the run if nothing transfers for too long.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || size_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("** byte_ring_fifo_watermark_core: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. The whole stimulus is queued at time zero; the driver then
  // works through it while this block waits for the end.
  // ---------------------------------------------------------------------------
  initial begin
    int             total;
    int             phase_len;
    int             mix;
    brfw_pkg::cnt_t sz;

    // Predictor starts in the reset state of the block.
    resize_ring(brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP));

    // Directed part. Empty-FIFO corner cases first, at the reset size.
    push_request(brfw_pkg::REQ_STATUS, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'hFF, 16'hFFFF);
    push_request(brfw_pkg::REQ_REMOVE, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_REMOVE, 8'h00, 16'hFFFF);
    push_request(brfw_pkg::REQ_ADD, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_ADD, 8'hFF, 16'hFFFF);
    push_request(brfw_pkg::REQ_ADD, 8'hA5, 16'h0000);
    push_request(brfw_pkg::REQ_ADD, 8'h5A, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_REMOVE, 8'h00, 16'h0001);
    push_request(brfw_pkg::REQ_STATUS, 8'h00, 16'h0000);
    // A remove larger than the fill level is clamped to what is held.
    push_request(brfw_pkg::REQ_REMOVE, 8'h00, 16'hFFFF);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    // A size below the minimum is taken as the minimum ring of two entries,
    // which holds one byte; the second add is refused and counted.
    push_control(OP_RESIZE, 9'd0);
    push_request(brfw_pkg::REQ_ADD, 8'h3C, 16'h0000);
    push_request(brfw_pkg::REQ_ADD, 8'hC3, 16'h0000);
    push_request(brfw_pkg::REQ_STATUS, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_REMOVE, 8'h00, 16'h0005);
    // A size above the cap is taken as the cap.
    push_control(OP_RESIZE, 9'h1FF);
    push_request(brfw_pkg::REQ_ADD, 8'h81, 16'h0000);
    push_request(brfw_pkg::REQ_STATUS, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    push_control(OP_RESIZE, 9'd3);
    push_request(brfw_pkg::REQ_ADD, 8'h11, 16'h0000);
    push_request(brfw_pkg::REQ_ADD, 8'h22, 16'h0000);
    push_request(brfw_pkg::REQ_ADD, 8'h33, 16'h0000);

    // Random phases, each at a fresh size. Small rings dominate so that the
    // full and wrap-around conditions come up often.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       sz = brfw_pkg::cnt_t'($urandom_range(0, MIN_SIZE));
        1:       sz = 9'd3;
        2:       sz = brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP);
        3:       sz = brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP - 1);
        4:       sz = brfw_pkg::cnt_t'($urandom_range(brfw_pkg::SIZE_CAP + 1, 511));
        default: sz = brfw_pkg::cnt_t'($urandom_range(MIN_SIZE, 40));
      endcase
      push_control(OP_RESIZE, sz);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 200);
      mix       = $urandom_range(0, 2);
      for (int i = 0; i < phase_len; i++) begin
        // Switch between idling and back-to-back transfers halfway through.
        if (i == phase_len / 2) no_idle = !no_idle;
        // Now and then the sender stops until every reply is back.
        if ($urandom_range(0, 59) == 0) push_control(OP_DRAIN, '0);
        case (mix)
          0:       push_random_request(55, 20, 10);
          1:       push_random_request(25, 45, 15);
          default: push_random_request(35, 35, 10);
        endcase
      end
      total += phase_len;
    end

    // Fill the largest ring to the brim and push against the limit.
    push_control(OP_RESIZE, brfw_pkg::cnt_t'(brfw_pkg::SIZE_CAP));
    no_idle = 1'b0;
    for (int i = 0; i < 300; i++) push_random_request(85, 5, 2);

    // Refused adds in a row: the minimum ring holds one byte, then every
    // further add is refused and counted.
    push_control(OP_RESIZE, 9'd2);
    no_idle = 1'b1;
    push_request(brfw_pkg::REQ_ADD, brfw_pkg::data_t'($urandom), 16'h0000);
    for (int i = 0; i < 30; i++)
      push_request(brfw_pkg::REQ_ADD, brfw_pkg::data_t'($urandom), 16'h0000);
    push_request(brfw_pkg::REQ_STATUS, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    push_request(brfw_pkg::REQ_GET, 8'h00, 16'h0000);
    push_control(OP_DRAIN, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sampling on the falling edge keeps the end check clear of the updates
    // made at the rising edge.
    do @(negedge clk); while (!drained);
    if (expected_replies.size() != 0) begin
      $error("%0d expected results never arrived", expected_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("** byte_ring_fifo_watermark_core: PASSED **");
    end else begin
      $display("** byte_ring_fifo_watermark_core: FAILED **");
    end
    $finish;
  end

endmodule
